@@ design/tsoc_pkg.sv @@
// Shared widths, codes and payload types for the trend sigma outlier check.
package tsoc_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int SAMPLE_SQ_W = 2 * SAMPLE_W;
    localparam int COUNT_W     = 13;
    localparam int MAX_POINTS  = 4096;
    localparam int SUM_W       = 36;
    localparam int SQ_W        = 59;
    localparam int K_W         = 4;
    localparam int KSQ_W       = 2 * K_W;
    localparam int NY_W        = COUNT_W + 1 + SAMPLE_W;
    localparam int DMAG_W      = NY_W - 1;

    // Iterative multiplier: one DIGIT_W slice of the B operand per cycle.
    localparam int MUL_A_W     = 72;
    localparam int MUL_B_W     = 40;
    localparam int DIGIT_W     = 8;
    localparam int MUL_DIGITS  = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W   = 3;
    localparam int PROD_W      = MUL_A_W + DIGIT_W;

    localparam logic [K_W-1:0] SIGMA_RESET = 4'd3;

    typedef logic [1:0] mul_op_t;
    localparam mul_op_t OP_DD = 2'd0;
    localparam mul_op_t OP_NQ = 2'd1;
    localparam mul_op_t OP_SS = 2'd2;
    localparam mul_op_t OP_VK = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_last;
    } item_t;

    typedef struct packed {
        logic quality_bad;
        logic history_overflow;
    } result_t;

    typedef struct packed {
        logic    hist_en;
        logic    last_en;
        logic    ny_en;
        logic    d_en;
        logic    mul_start;
        mul_op_t mul_op;
        logic    var_en;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic mul_done;
    } status_t;

endpackage

@@ design/tsoc_mul.sv @@
// Iterative unsigned multiplier that consumes one digit of the B operand per cycle.
module tsoc_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tsoc_pkg::MUL_A_W-1:0]  a,
    input  logic [tsoc_pkg::MUL_B_W-1:0]  b,
    output logic                          done,
    output logic [tsoc_pkg::PROD_W-1:0]   product
);

    logic [tsoc_pkg::MUL_A_W-1:0]   a_reg;
    logic [tsoc_pkg::MUL_B_W-1:0]   b_reg;
    logic [tsoc_pkg::PROD_W-1:0]    acc_reg;
    logic [tsoc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [tsoc_pkg::MUL_CNT_W-1:0] cnt_next;
    logic                           done_reg;
    logic                           done_next;
    logic [tsoc_pkg::PROD_W-1:0]    partial;
    logic [tsoc_pkg::PROD_W-1:0]    acc_step;

    // Horner form: shift the running product up one digit and add the next row.
    always_comb
    begin
        partial  = a_reg * b_reg[tsoc_pkg::MUL_B_W-1 -: tsoc_pkg::DIGIT_W];
        acc_step = {acc_reg[tsoc_pkg::PROD_W-tsoc_pkg::DIGIT_W-1:0],
                    {tsoc_pkg::DIGIT_W{1'b0}}} + partial;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = tsoc_pkg::MUL_CNT_W'(tsoc_pkg::MUL_DIGITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == tsoc_pkg::MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_step;
            b_reg   <= b_reg << tsoc_pkg::DIGIT_W;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ design/tsoc_ctrl.sv @@
// Sequencing state machine for history updates and the end-of-series test.
module tsoc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              is_last,
    input  tsoc_pkg::status_t status,
    output tsoc_pkg::cmd_t    cmd,
    output logic              busy
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NY     = 4'd1;
    localparam logic [3:0] ST_DIFF   = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_DD_GO  = 4'd4;
    localparam logic [3:0] ST_DD_RUN = 4'd5;
    localparam logic [3:0] ST_NQ_GO  = 4'd6;
    localparam logic [3:0] ST_NQ_RUN = 4'd7;
    localparam logic [3:0] ST_SS_GO  = 4'd8;
    localparam logic [3:0] ST_SS_RUN = 4'd9;
    localparam logic [3:0] ST_VAR    = 4'd10;
    localparam logic [3:0] ST_VK_GO  = 4'd11;
    localparam logic [3:0] ST_VK_RUN = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = tsoc_pkg::OP_DD;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_last)
                    begin
                        cmd.last_en = 1'b1;
                        state_next  = ST_NY;
                    end
                    else
                    begin
                        cmd.hist_en = 1'b1;
                    end
                end
            end
            ST_NY:
            begin
                cmd.ny_en  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.d_en   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = status.skip ? ST_DONE : ST_DD_GO;
            end
            ST_DD_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_DD_RUN;
            end
            ST_DD_RUN:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_NQ_GO;
                end
            end
            ST_NQ_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = tsoc_pkg::OP_NQ;
                state_next    = ST_NQ_RUN;
            end
            ST_NQ_RUN:
            begin
                cmd.mul_op = tsoc_pkg::OP_NQ;
                if (status.mul_done)
                begin
                    state_next = ST_SS_GO;
                end
            end
            ST_SS_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = tsoc_pkg::OP_SS;
                state_next    = ST_SS_RUN;
            end
            ST_SS_RUN:
            begin
                cmd.mul_op = tsoc_pkg::OP_SS;
                if (status.mul_done)
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                cmd.var_en = 1'b1;
                state_next = ST_VK_GO;
            end
            ST_VK_GO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = tsoc_pkg::OP_VK;
                state_next    = ST_VK_RUN;
            end
            ST_VK_RUN:
            begin
                cmd.mul_op = tsoc_pkg::OP_VK;
                if (status.mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ design/tsoc_dp.sv @@
// Datapath: history accumulators, the spread test arithmetic and the result register.
module tsoc_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsoc_pkg::cmd_t             cmd,
    input  tsoc_pkg::item_t            item,
    input  logic                       cfg_we,
    input  logic [tsoc_pkg::K_W-1:0]   cfg_data,
    output tsoc_pkg::status_t          status,
    output logic                       result_valid,
    output tsoc_pkg::result_t          result
);

    logic [tsoc_pkg::COUNT_W-1:0]      count_reg;
    logic signed [tsoc_pkg::SUM_W-1:0] sum_reg;
    logic [tsoc_pkg::SQ_W-1:0]         sq_sum_reg;
    logic                              overflow_reg;
    logic [tsoc_pkg::SAMPLE_SQ_W-1:0]  sq_pend_reg;
    logic                              sq_pend_valid_reg;
    logic [tsoc_pkg::K_W-1:0]          sigma_reg;
    logic                              result_valid_reg;
    tsoc_pkg::result_t                 result_reg;

    logic signed [tsoc_pkg::SAMPLE_W-1:0] y_reg;
    logic                                 empty_reg;
    logic signed [tsoc_pkg::NY_W-1:0]     ny_reg;
    logic signed [tsoc_pkg::NY_W-1:0]     d_reg;
    logic [tsoc_pkg::PROD_W-1:0]          lhs_reg;
    logic [tsoc_pkg::PROD_W-1:0]          nq_reg;
    logic [tsoc_pkg::PROD_W-1:0]          ss_reg;
    logic [tsoc_pkg::PROD_W-1:0]          var_reg;

    logic signed [tsoc_pkg::SAMPLE_SQ_W-1:0] y_sq;
    logic                                    has_room;
    logic [tsoc_pkg::DMAG_W-1:0]             d_mag;
    logic [tsoc_pkg::SUM_W-1:0]              s_mag;
    logic [tsoc_pkg::KSQ_W-1:0]              k_sq;
    logic [tsoc_pkg::MUL_A_W-1:0]            mul_a;
    logic [tsoc_pkg::MUL_B_W-1:0]            mul_b;
    logic                                    mul_done;
    logic [tsoc_pkg::PROD_W-1:0]             mul_product;
    logic                                    d_neg;

    always_comb
    begin
        y_sq     = item.sample * item.sample;
        has_room = (count_reg < tsoc_pkg::COUNT_W'(tsoc_pkg::MAX_POINTS));
        d_neg    = d_reg[tsoc_pkg::NY_W-1];
        d_mag    = d_reg[tsoc_pkg::DMAG_W-1:0];
        s_mag    = sum_reg[tsoc_pkg::SUM_W-1] ? tsoc_pkg::SUM_W'(-sum_reg)
                                              : tsoc_pkg::SUM_W'(sum_reg);
        k_sq     = sigma_reg * sigma_reg;
    end

    always_comb
    begin
        case (cmd.mul_op)
            tsoc_pkg::OP_DD:
            begin
                mul_a = tsoc_pkg::MUL_A_W'(d_mag);
                mul_b = tsoc_pkg::MUL_B_W'(d_mag);
            end
            tsoc_pkg::OP_NQ:
            begin
                mul_a = tsoc_pkg::MUL_A_W'(sq_sum_reg);
                mul_b = tsoc_pkg::MUL_B_W'(count_reg);
            end
            tsoc_pkg::OP_SS:
            begin
                mul_a = tsoc_pkg::MUL_A_W'(s_mag);
                mul_b = tsoc_pkg::MUL_B_W'(s_mag);
            end
            default:
            begin
                mul_a = var_reg[tsoc_pkg::MUL_A_W-1:0];
                mul_b = tsoc_pkg::MUL_B_W'(k_sq);
            end
        endcase
    end

    tsoc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // Each history square is staged in sq_pend_reg, then added to sq_sum_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            sum_reg           <= '0;
            sq_sum_reg        <= '0;
            overflow_reg      <= 1'b0;
            sq_pend_valid_reg <= 1'b0;
            sigma_reg         <= tsoc_pkg::SIGMA_RESET;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            result_valid_reg  <= cmd.finish;
            sq_pend_valid_reg <= cmd.hist_en && has_room;
            if (cfg_we)
            begin
                sigma_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                count_reg    <= '0;
                sum_reg      <= '0;
                sq_sum_reg   <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (sq_pend_valid_reg)
                begin
                    sq_sum_reg <= sq_sum_reg + tsoc_pkg::SQ_W'(sq_pend_reg);
                end
                if (cmd.hist_en)
                begin
                    if (has_room)
                    begin
                        count_reg <= count_reg + 1'b1;
                        sum_reg   <= sum_reg + tsoc_pkg::SUM_W'(item.sample);
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_en)
        begin
            sq_pend_reg <= tsoc_pkg::SAMPLE_SQ_W'(y_sq);
        end
        if (cmd.last_en)
        begin
            y_reg     <= item.sample;
            empty_reg <= (count_reg == '0);
        end
        if (cmd.ny_en)
        begin
            ny_reg <= $signed({1'b0, count_reg}) * y_reg;
        end
        if (cmd.d_en)
        begin
            d_reg <= ny_reg - tsoc_pkg::NY_W'(sum_reg);
        end
        if (mul_done)
        begin
            case (cmd.mul_op)
                tsoc_pkg::OP_DD: lhs_reg <= mul_product;
                tsoc_pkg::OP_NQ: nq_reg  <= mul_product;
                tsoc_pkg::OP_SS: ss_reg  <= mul_product;
                default:
                begin
                end
            endcase
        end
        if (cmd.var_en)
        begin
            var_reg <= (nq_reg >= ss_reg) ? (nq_reg - ss_reg) : '0;
        end
        if (cmd.finish)
        begin
            result_reg.quality_bad      <= empty_reg
                                           || (!d_neg && !(lhs_reg < mul_product));
            result_reg.history_overflow <= overflow_reg;
        end
    end

    assign status.skip     = empty_reg || d_neg;
    assign status.mul_done = mul_done;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

endmodule

@@ design/trend_sigma_outlier_check.sv @@
// Top level of the trend sigma outlier check: controller plus datapath.
//
// The block takes a trend series one signed Q16.8 sample per beat on the item
// port. A beat is accepted at a rising edge where start is high and busy is low.
// Samples with is_last low are history: they update a count, a sum and a sum of
// squares, and the block takes one such beat every cycle with busy staying low.
// Once MAX_POINTS history samples are held, further history beats are dropped
// and remembered as an overflow.
// A beat with is_last high is tested against the history. It is good when its
// excess over the mean is strictly below sigma_multiple population standard
// deviations, checked exactly as (n*y - S)^2 < k^2 * (n*Q - S^2). An empty
// history gives a bad result. After the test all history clears.
// busy is high while the test runs. The result beat appears on result with
// result_valid high for one cycle. With an empty history or a sample below the
// mean the test goes from ST_CHECK straight to ST_DONE; otherwise it forms four
// products on one shared multiplier that handles one 8-bit digit per cycle.
// The receiver cannot stall; the result register simply holds one beat.
// sigma_multiple is written through cfg_we and cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Reset clears the history, the overflow flag and sets sigma_multiple to 3.
module trend_sigma_outlier_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tsoc_pkg::item_t           item,
    output logic                      result_valid,
    output tsoc_pkg::result_t         result,
    input  logic                      cfg_we,
    input  logic [tsoc_pkg::K_W-1:0]  cfg_data
);

    tsoc_pkg::cmd_t    cmd;
    tsoc_pkg::status_t status;

    // The controller sequences the end-of-series test and gates history beats.
    tsoc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (item.is_last),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    // The datapath holds the accumulators, the shared multiplier and the result.
    tsoc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the trend sigma outlier check.
module testbench;

    localparam int ITEM_W = $bits(tsoc_pkg::item_t);

    // Predicts the verdict of each series and checks the result beats in order.
    // It keeps its own count, sum and sum of squares of the history samples and
    // evaluates the cross-multiplied test (n*y - S)^2 < k^2 * (n*Q - S^2) with
    // 128-bit unsigned products, so nothing wraps even for a full history of
    // extreme samples.
    class verdict_tracker;
        logic [tsoc_pkg::COUNT_W-1:0]      points;
        logic signed [tsoc_pkg::SUM_W-1:0] total;
        logic [tsoc_pkg::SQ_W-1:0]         square_total;
        bit                                dropped;
        logic [tsoc_pkg::K_W-1:0]          multiple;
        tsoc_pkg::result_t                 verdicts_due[$];
        int                                errors;

        function new();
            points       = '0;
            total        = '0;
            square_total = '0;
            dropped      = 1'b0;
            multiple     = tsoc_pkg::SIGMA_RESET;
            errors       = 0;
        endfunction

        function void set_multiple(logic [tsoc_pkg::K_W-1:0] value);
            multiple = value;
        endfunction

        function int waiting();
            return verdicts_due.size();
        endfunction

        // Called for every accepted sample beat.
        function void take_sample(tsoc_pkg::item_t beat);
            longint            y;
            longint            n;
            longint            d;
            longint            mag;
            logic [127:0]      d_wide;
            logic [127:0]      excess_sq;
            logic [127:0]      n_times_q;
            logic [127:0]      sum_sq;
            logic [127:0]      spread;
            logic [127:0]      bound;
            tsoc_pkg::result_t verdict;
            y = beat.sample;
            if (!beat.is_last)
            begin
                // A full history drops the sample but remembers that it did.
                if (points < tsoc_pkg::MAX_POINTS)
                begin
                    points       = points + 1'b1;
                    total        = total + tsoc_pkg::SUM_W'(y);
                    square_total = square_total + tsoc_pkg::SQ_W'(y * y);
                end
                else
                begin
                    dropped = 1'b1;
                end
                return;
            end
            if (points == 0)
            begin
                verdict.quality_bad = 1'b1;
            end
            else
            begin
                n = longint'(points);
                d = n * y - longint'(total);
                if (d < 0)
                begin
                    verdict.quality_bad = 1'b0;
                end
                else
                begin
                    d_wide    = 128'(d);
                    excess_sq = d_wide * d_wide;
                    n_times_q = 128'(points);
                    n_times_q = n_times_q * 128'(square_total);
                    mag = longint'(total);
                    if (mag < 0)
                        mag = -mag;
                    sum_sq = 128'(mag);
                    sum_sq = sum_sq * sum_sq;
                    spread = (n_times_q > sum_sq) ? n_times_q - sum_sq : '0;
                    bound  = spread * 128'(multiple) * 128'(multiple);
                    verdict.quality_bad = !(excess_sq < bound);
                end
            end
            verdict.history_overflow = dropped;
            verdicts_due.push_back(verdict);
            points       = '0;
            total        = '0;
            square_total = '0;
            dropped      = 1'b0;
        endfunction

        // Called for every result beat.
        function void check_verdict(tsoc_pkg::result_t got);
            tsoc_pkg::result_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("result beat with no verdict pending: quality_bad=%0b history_overflow=%0b",
                       got.quality_bad, got.history_overflow);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.quality_bad !== want.quality_bad)
            begin
                $error("quality_bad: expected %0b, got %0b", want.quality_bad, got.quality_bad);
                errors++;
            end
            if (got.history_overflow !== want.history_overflow)
            begin
                $error("history_overflow: expected %0b, got %0b",
                       want.history_overflow, got.history_overflow);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    tsoc_pkg::item_t          item;
    logic                     result_valid;
    tsoc_pkg::result_t        result;
    logic                     cfg_we;
    logic [tsoc_pkg::K_W-1:0] cfg_data;

    verdict_tracker sb;

    // Sender pacing: when gaps are on, beats go out in bursts of random length
    // separated by random idle stretches with start low.
    bit                       gaps_on;
    int                       burst_left;
    int                       sent;
    int                       series_len;
    logic [tsoc_pkg::K_W-1:0] phase_multiple [6];

    trend_sigma_outlier_check dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Monitor. Everything is sampled at the rising edge, before the block's own
    // registers update, so a beat is seen exactly at the edge that accepts it.
    // A result beat lasts one cycle and cannot be held off.
    always @(posedge clk)
    begin
        if (result_valid)
            sb.check_verdict(result);
        if (rst_n && start && !busy)
            sb.take_sample(item);
    end

    function automatic longint clamp_sample(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // A value drawn uniformly from center +/- spread, clamped into range.
    function automatic longint near(longint center, longint spread);
        longint off;
        off = $urandom_range(0, 32'(2 * spread));
        return clamp_sample(center + off - spread);
    endfunction

    function automatic longint any_sample();
        longint raw;
        raw = $urandom_range(0, 24'hFFFFFF);
        return raw - 64'sd8388608;
    endfunction

    // Drives one sample beat and returns at the edge that accepts it. Start
    // stays high so the next beat can follow in the very next cycle.
    task automatic send_point(longint value, bit last);
        tsoc_pkg::item_t beat;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                item  <= tsoc_pkg::item_t'(ITEM_W'($urandom));
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        beat.sample  = value[tsoc_pkg::SAMPLE_W-1:0];
        beat.is_last = last;
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Lowers start and waits until every verdict has arrived. History beats
    // give no result, so a further wait that covers the longest test path follows
    // before anything else happens.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_multiple(logic [tsoc_pkg::K_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= tsoc_pkg::K_W'($urandom);
        sb.set_multiple(value);
    endtask

    // One random series: history clustered around a random center with a
    // spread from zero up to half of the range, an occasional wild sample,
    // and a final point placed from well below to well above the threshold.
    task automatic run_series(int len);
        longint center;
        longint spread;
        int     i;
        center  = any_sample();
        spread  = ($urandom_range(0, 9) == 0) ? 0 : (64'sd1 << $urandom_range(0, 22));
        gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_point(any_sample(), 1'b0);
            else
                send_point(near(center, spread), 1'b0);
        end
        if ($urandom_range(0, 9) == 0)
            send_point(any_sample(), 1'b1);
        else
            send_point(near(center, spread * $urandom_range(0, 5)), 1'b1);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        burst_left = 0;
        sent       = 0;
        series_len = 0;
        sb         = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed series at the reset multiple of three.
        // An empty history is always bad.
        send_point(0, 1'b1);
        // Both extremes in the history, final point far below the mean.
        send_point(8388607, 1'b0);
        send_point(-8388608, 1'b0);
        send_point(-8388608, 1'b1);
        // Zero spread: a point equal to the mean is bad, one below it is good.
        send_point(100, 1'b0);
        send_point(100, 1'b0);
        send_point(100, 1'b0);
        send_point(100, 1'b1);
        send_point(100, 1'b0);
        send_point(100, 1'b0);
        send_point(99, 1'b1);
        // Largest possible excess against a flat negative history.
        send_point(-8388608, 1'b0);
        send_point(-8388608, 1'b0);
        send_point(8388607, 1'b1);
        // Ordinary spread, one point inside and one outside.
        send_point(0, 1'b0);
        send_point(256, 1'b0);
        send_point(512, 1'b0);
        send_point(700, 1'b1);
        send_point(0, 1'b0);
        send_point(256, 1'b0);
        send_point(512, 1'b0);
        send_point(1023, 1'b1);

        // A multiple of zero: only a point strictly below the mean is good.
        settle();
        write_multiple(4'd0);
        send_point(10, 1'b0);
        send_point(20, 1'b0);
        send_point(14, 1'b1);
        send_point(10, 1'b0);
        send_point(20, 1'b0);
        send_point(15, 1'b1);

        // Random phases, each under its own multiple, extremes included.
        phase_multiple[0] = 4'd1;
        phase_multiple[1] = 4'd15;
        phase_multiple[2] = 4'd0;
        phase_multiple[3] = 4'd3;
        phase_multiple[4] = tsoc_pkg::K_W'($urandom);
        phase_multiple[5] = tsoc_pkg::K_W'($urandom);
        foreach (phase_multiple[p])
        begin
            settle();
            write_multiple(phase_multiple[p]);
            sent = 0;
            while (sent < 145)
            begin
                case ($urandom_range(0, 9))
                    0:       series_len = ($urandom_range(0, 2) == 0) ? 0
                                                                      : $urandom_range(30, 120);
                    default: series_len = $urandom_range(1, 20);
                endcase
                run_series(series_len);
                sent += series_len + 1;
            end
        end

        settle();
        if (sb.errors == 0)
            $display("[trend_sigma_outlier_check] OK");
        else
            $display("[trend_sigma_outlier_check] ERROR");
        $finish;
    end

    // Safety net: the slowest correct run stays far below this.
    initial
    begin
        #2000000;
        $display("[trend_sigma_outlier_check] ERROR");
        $finish;
    end

endmodule
